// File: rtl/lcd_pkg.sv
package lcd_pkg;

	// Operation codes carried by operation and echoed on result_kind.
	typedef enum logic [1:0] {
		OP_BOX      = 2'd0,
		OP_KEYPOINT = 2'd1,
		OP_ROTATED  = 2'd2,
		OP_NONE     = 2'd3
	} op_t;

	// Register word index, taken from paddr[4:2].
	typedef enum logic [2:0] {
		REG_LEFT_PAD     = 3'd0,
		REG_PAD_TOP      = 3'd1,
		REG_SCALE        = 3'd2,
		REG_IMAGE_WIDTH  = 3'd3,
		REG_IMAGE_HEIGHT = 3'd4
	} reg_addr_t;

	localparam int SCALE_ONE_BITS = 12;
	localparam int ANGLE_SHIFT = 24;
	// 180/pi in Q.16.
	localparam logic signed [22:0] DEG_PER_RAD_Q16 = 23'sd3754936;

	localparam logic [11:0] LEFT_PAD_RESET = 12'd0;
	localparam logic [11:0] PAD_TOP_RESET = 12'd0;
	localparam logic [15:0] SCALE_RESET = 16'd4096;
	localparam logic [12:0] IMAGE_WIDTH_RESET = 13'd640;
	localparam logic [12:0] IMAGE_HEIGHT_RESET = 13'd640;

endpackage

// File: rtl/lcd_in_if.sv
interface lcd_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         operation;
	logic signed [15:0] in_x;
	logic signed [15:0] in_y;
	logic signed [15:0] in_w;
	logic signed [15:0] in_h;
	logic [15:0]        in_conf;
	logic signed [14:0] in_angle;

	modport source(output valid, output operation, output in_x, output in_y, output in_w,
		output in_h, output in_conf, output in_angle, input ready);
	modport sink(input valid, input operation, input in_x, input in_y, input in_w,
		input in_h, input in_conf, input in_angle, output ready);
endinterface

// File: rtl/lcd_out_if.sv
interface lcd_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         result_kind;
	logic [15:0]        out_x;
	logic [15:0]        out_y;
	logic [15:0]        out_w;
	logic [15:0]        out_h;
	logic [15:0]        out_conf;
	logic signed [12:0] out_angle;

	modport source(output valid, output result_kind, output out_x, output out_y,
		output out_w, output out_h, output out_conf, output out_angle, input ready);
	modport sink(input valid, input result_kind, input out_x, input out_y,
		input out_w, input out_h, input out_conf, input out_angle, output ready);
endinterface

// File: rtl/letterbox_coordinate_decode_top.sv
// Register path: stage 1, stage 2, the divider stages, stage 3, then the output register.
// Throughput: one beat per cycle; the restoring divider is unrolled into one register
// stage per quotient bit, so the four coordinate lanes never share a unit.
// Backpressure stalls the whole pipeline together; bubbles are not squeezed out.
// Reset (arst_n low, asynchronous) clears all valid bits and loads the register
// defaults: no padding, unit scale, 640 by 640 image.
module letterbox_coordinate_decode_top #(
	parameter int FRAC_BITS = 4,
	parameter int DIM_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	lcd_in_if.sink      in_ch,
	lcd_out_if.source   out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// Quotient bits needed: the clamp bound (dim - 1) * 2^F stays below 2^QB.
	localparam int QB = DIM_BITS + FRAC_BITS;
	// Every lane works in Q.(F+1) so the box corners 2c -/+ size are exact.
	localparam int VW = 18;
	localparam int PW = 12 + FRAC_BITS + 1;
	localparam int NW = ((VW > PW) ? VW : PW) + 1;
	localparam int NUW = NW - 1 + lcd_pkg::SCALE_ONE_BITS;
	localparam int DW = 17;
	localparam int CW = ((NUW > DW + QB) ? NUW : DW + QB) + 1;
	localparam int CAP = 1 << DIM_BITS;
	localparam logic [QB-1:0] FLOOR_MASK = ~QB'((1 << FRAC_BITS) - 1);
	localparam logic [15:0] FLOOR_MASK16 = ~16'((1 << FRAC_BITS) - 1);

	typedef struct packed {
		logic [1:0]         op;
		logic [15:0]        conf;
		logic [QB-1:0]      hi_x;
		logic [QB-1:0]      hi_y;
		logic [DW-1:0]      div;
	} side1_t;

	typedef struct packed {
		logic [1:0]         op;
		logic [15:0]        conf;
		logic signed [12:0] ang;
		logic [QB-1:0]      hi_x;
		logic [QB-1:0]      hi_y;
		logic [DW-1:0]      div;
	} side_t;

	typedef struct packed {
		logic          pos;
		logic          sat;
		logic [CW-1:0] rem;
		logic [QB-1:0] quo;
	} lane_t;

	// ---------------------------------------------------------------------------
	// Configuration registers. A write lands in the access phase.
	// ---------------------------------------------------------------------------
	logic [11:0] left_pad_q;
	logic [11:0] pad_top_q;
	logic [15:0] scale_q;
	logic [12:0] image_width_q;
	logic [12:0] image_height_q;
	logic        cfg_wr;
	lcd_pkg::reg_addr_t cfg_addr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;
	assign cfg_addr = lcd_pkg::reg_addr_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_pad_q <= lcd_pkg::LEFT_PAD_RESET;
			pad_top_q <= lcd_pkg::PAD_TOP_RESET;
			scale_q <= lcd_pkg::SCALE_RESET;
			image_width_q <= lcd_pkg::IMAGE_WIDTH_RESET;
			image_height_q <= lcd_pkg::IMAGE_HEIGHT_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_addr)
				lcd_pkg::REG_LEFT_PAD:     left_pad_q <= pwdata[11:0];
				lcd_pkg::REG_PAD_TOP:      pad_top_q <= pwdata[11:0];
				lcd_pkg::REG_SCALE:        scale_q <= pwdata[15:0];
				lcd_pkg::REG_IMAGE_WIDTH:  image_width_q <= pwdata[12:0];
				lcd_pkg::REG_IMAGE_HEIGHT: image_height_q <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_addr)
			lcd_pkg::REG_LEFT_PAD:     prdata = 32'(left_pad_q);
			lcd_pkg::REG_PAD_TOP:      prdata = 32'(pad_top_q);
			lcd_pkg::REG_SCALE:        prdata = 32'(scale_q);
			lcd_pkg::REG_IMAGE_WIDTH:  prdata = 32'(image_width_q);
			lcd_pkg::REG_IMAGE_HEIGHT: prdata = 32'(image_height_q);
			default:                   prdata = 32'd0;
		endcase
	end

	// The pipeline moves as one whenever the output register is free or being taken.
	logic en;
	logic out_valid_s4;
	assign en = ~out_valid_s4 | out_ch.ready;
	assign in_ch.ready = en;

	// ---------------------------------------------------------------------------
	// Stage 1: form the four unpadded numerators in Q.(F+1), the divisor 2*scale,
	// the clamp bounds, and the angle product.
	// ---------------------------------------------------------------------------
	logic signed [VW-1:0] v_c [4];
	logic [11:0]          pad_c [4];
	logic signed [NW-1:0] n_c [4];
	logic [14:0]          dim_w_c;
	logic [14:0]          dim_h_c;
	logic [15:0]          scale_eff_c;
	side1_t               side1_c;
	logic signed [VW-1:0] x2_c, y2_c, w_c, h_c;

	function automatic logic [14:0] eff_dim(input logic [12:0] d);
		logic [14:0] e;
		if (d == 13'd0) begin
			e = 15'd1;
		end else if (32'(d) > CAP) begin
			e = 15'(CAP);
		end else begin
			e = 15'(d);
		end
		return e;
	endfunction

	always_comb begin
		x2_c = VW'(in_ch.in_x) <<< 1;
		y2_c = VW'(in_ch.in_y) <<< 1;
		w_c = VW'(in_ch.in_w);
		h_c = VW'(in_ch.in_h);
		v_c[0] = x2_c;
		v_c[1] = w_c <<< 1;
		v_c[2] = y2_c;
		v_c[3] = h_c <<< 1;
		pad_c[0] = left_pad_q;
		pad_c[1] = 12'd0;
		pad_c[2] = pad_top_q;
		pad_c[3] = 12'd0;
		unique case (lcd_pkg::op_t'(in_ch.operation))
			lcd_pkg::OP_BOX: begin
				// Corners from twice the center plus or minus the full size.
				v_c[0] = x2_c - w_c;
				v_c[1] = x2_c + w_c;
				v_c[2] = y2_c - h_c;
				v_c[3] = y2_c + h_c;
				pad_c[1] = left_pad_q;
				pad_c[3] = pad_top_q;
			end
			lcd_pkg::OP_KEYPOINT, lcd_pkg::OP_ROTATED, lcd_pkg::OP_NONE: ;
		endcase
		for (int k = 0; k < 4; k++) begin
			n_c[k] = NW'(v_c[k]) - $signed(NW'(pad_c[k]) << (FRAC_BITS + 1));
		end
		dim_w_c = eff_dim(image_width_q);
		dim_h_c = eff_dim(image_height_q);
		scale_eff_c = (scale_q == 16'd0) ? 16'd1 : scale_q;
		side1_c.op = in_ch.operation;
		side1_c.conf = in_ch.in_conf;
		side1_c.hi_x = QB'(dim_w_c - 15'd1) << FRAC_BITS;
		side1_c.hi_y = QB'(dim_h_c - 15'd1) << FRAC_BITS;
		side1_c.div = {scale_eff_c, 1'b0};
	end

	logic                 valid_s1;
	side1_t               side_s1;
	logic signed [NW-1:0] n_s1 [4];
	logic signed [37:0]   ang_prod_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side1_c;
			n_s1 <= n_c;
			ang_prod_s1 <= 38'(in_ch.in_angle) * 38'(lcd_pkg::DEG_PER_RAD_Q16);
		end
	end

	// ---------------------------------------------------------------------------
	// Stage 2: scale numerators by 4096, flag non-positive ones (they clamp to
	// zero), and flag quotients too large for the divider (they clamp high).
	// The angle is divided by 2^24 with truncation toward zero.
	// ---------------------------------------------------------------------------
	logic           valid_s2;
	side_t          side_s2;
	lane_t          lane_s2 [4];
	lane_t          lane_c [4];
	logic [CW-1:0]  div_top_c;
	logic signed [37:0] ang_bias_c;

	always_comb begin
		div_top_c = CW'(side_s1.div) << QB;
		for (int k = 0; k < 4; k++) begin
			lane_c[k].pos = (n_s1[k] > 0);
			lane_c[k].rem = lane_c[k].pos
				? (CW'(n_s1[k][NW-2:0]) << lcd_pkg::SCALE_ONE_BITS) : '0;
			lane_c[k].sat = (lane_c[k].rem >= div_top_c);
			lane_c[k].quo = '0;
		end
		ang_bias_c = ang_prod_s1
			+ (ang_prod_s1[37] ? 38'sd16777215 : 38'sd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2.op <= side_s1.op;
			side_s2.conf <= side_s1.conf;
			side_s2.hi_x <= side_s1.hi_x;
			side_s2.hi_y <= side_s1.hi_y;
			side_s2.div <= side_s1.div;
			side_s2.ang <= 13'(ang_bias_c >>> lcd_pkg::ANGLE_SHIFT);
			lane_s2 <= lane_c;
		end
	end

	// ---------------------------------------------------------------------------
	// Divider: one restoring step per register stage, most significant quotient
	// bit first. Stage k decides quotient bit QB-1-k for all four lanes.
	// ---------------------------------------------------------------------------
	logic  valid_sd [QB];
	side_t side_sd [QB];
	lane_t lane_sd [QB][4];

	for (genvar g = 0; g < QB; g++) begin : g_div
		logic  vin;
		side_t sin;
		lane_t lin [4];
		lane_t lout [4];
		logic [CW-1:0] dsh;

		if (g == 0) begin : g_first
			assign vin = valid_s2;
			assign sin = side_s2;
			assign lin = lane_s2;
		end else begin : g_next
			assign vin = valid_sd[g-1];
			assign sin = side_sd[g-1];
			assign lin = lane_sd[g-1];
		end

		always_comb begin
			dsh = CW'(sin.div) << (QB - 1 - g);
			for (int k = 0; k < 4; k++) begin
				lout[k] = lin[k];
				if (lin[k].rem >= dsh) begin
					lout[k].rem = lin[k].rem - dsh;
					lout[k].quo[QB-1-g] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_sd[g] <= 1'b0;
			end else if (en) begin
				valid_sd[g] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_sd[g] <= sin;
				lane_sd[g] <= lout;
			end
		end
	end

	// ---------------------------------------------------------------------------
	// Stage 3: clamp each lane to [0, (dim - 1) * 2^F].
	// ---------------------------------------------------------------------------
	logic          valid_s3;
	side_t         side_s3;
	logic [QB-1:0] clamp_s3 [4];
	logic [QB-1:0] clamp_c [4];
	side_t         side_last;
	lane_t         lane_last [4];
	logic [QB-1:0] hi_c;

	assign side_last = side_sd[QB-1];
	assign lane_last = lane_sd[QB-1];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			hi_c = (k < 2) ? side_last.hi_x : side_last.hi_y;
			if (!lane_last[k].pos) begin
				clamp_c[k] = '0;
			end else if (lane_last[k].sat || lane_last[k].quo > hi_c) begin
				clamp_c[k] = hi_c;
			end else begin
				clamp_c[k] = lane_last[k].quo;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_sd[QB-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= side_last;
			clamp_s3 <= clamp_c;
		end
	end

	// ---------------------------------------------------------------------------
	// Stage 4: per-mode floors, box extent, and zeroing of unused fields. This is
	// the output register.
	// ---------------------------------------------------------------------------
	logic [15:0]        ox_c, oy_c, ow_c, oh_c, oc_c;
	logic signed [12:0] oa_c;
	logic [1:0]         kind_s4;
	logic [15:0]        ox_s4, oy_s4, ow_s4, oh_s4, oc_s4;
	logic signed [12:0] oa_s4;

	always_comb begin
		ox_c = '0;
		oy_c = '0;
		ow_c = '0;
		oh_c = '0;
		oc_c = '0;
		oa_c = '0;
		unique case (lcd_pkg::op_t'(side_s3.op))
			lcd_pkg::OP_BOX: begin
				ox_c = 16'(clamp_s3[0] & FLOOR_MASK);
				oy_c = 16'(clamp_s3[2] & FLOOR_MASK);
				if (clamp_s3[1] > clamp_s3[0]) begin
					ow_c = 16'((clamp_s3[1] - clamp_s3[0]) & FLOOR_MASK);
				end
				if (clamp_s3[3] > clamp_s3[2]) begin
					oh_c = 16'((clamp_s3[3] - clamp_s3[2]) & FLOOR_MASK);
				end
			end
			lcd_pkg::OP_KEYPOINT: begin
				ox_c = 16'(clamp_s3[0]);
				oy_c = 16'(clamp_s3[2]);
				oc_c = side_s3.conf;
			end
			lcd_pkg::OP_ROTATED: begin
				ox_c = 16'(clamp_s3[0] & FLOOR_MASK);
				ow_c = 16'(clamp_s3[1] & FLOOR_MASK);
				oy_c = 16'(clamp_s3[2] & FLOOR_MASK);
				oh_c = 16'(clamp_s3[3] & FLOOR_MASK);
				oa_c = side_s3.ang;
			end
			lcd_pkg::OP_NONE: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s4 <= 1'b0;
		end else if (en) begin
			out_valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s4 <= side_s3.op;
			ox_s4 <= ox_c;
			oy_s4 <= oy_c;
			ow_s4 <= ow_c;
			oh_s4 <= oh_c;
			oc_s4 <= oc_c;
			oa_s4 <= oa_c;
		end
	end

	assign out_ch.valid = out_valid_s4;
	assign out_ch.result_kind = kind_s4;
	assign out_ch.out_x = ox_s4;
	assign out_ch.out_y = oy_s4;
	assign out_ch.out_w = ow_s4;
	assign out_ch.out_h = oh_s4;
	assign out_ch.out_conf = oc_s4;
	assign out_ch.out_angle = oa_s4;

	// ---------------------------------------------------------------------------
	// Checks on the result path.
	// ---------------------------------------------------------------------------
	a_keypoint_no_size: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.result_kind == lcd_pkg::OP_KEYPOINT
		|-> out_ch.out_w == 16'd0 && out_ch.out_h == 16'd0 && out_ch.out_angle == 13'sd0)
		else $error("keypoint result carries size or angle");

	a_unknown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.result_kind == lcd_pkg::OP_NONE
		|-> out_ch.out_x == 16'd0 && out_ch.out_y == 16'd0 && out_ch.out_w == 16'd0
			&& out_ch.out_h == 16'd0 && out_ch.out_conf == 16'd0)
		else $error("unknown operation produced nonzero fields");

	a_conf_keypoint_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.result_kind != lcd_pkg::OP_KEYPOINT
		|-> out_ch.out_conf == 16'd0)
		else $error("confidence leaked into a non-keypoint result");

	a_box_floored: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.result_kind == lcd_pkg::OP_BOX
		|-> (out_ch.out_x & ~FLOOR_MASK16) == 16'd0 && (out_ch.out_w & ~FLOOR_MASK16) == 16'd0
			&& out_ch.out_angle == 13'sd0)
		else $error("box result not floored");

	a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> $stable(valid_s3) && $stable(clamp_s3[0]))
		else $error("pipeline advanced under a stall");

endmodule
